@@ rtl/sfp_pkg.sv @@
// Package for the substring first-position search block.
// Holds sizing constants, beat payload types, codes and the cell control struct.
// No dependencies.
package sfp_pkg;

    localparam int                MAX_PATTERN = 16;
    localparam longint unsigned   MAX_TEXT    = 64'd65535;

    localparam logic       REQ_PATTERN = 1'b0;
    localparam logic       REQ_TEXT    = 1'b1;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_PATTERN_LONG = 2'd1;
    localparam logic [1:0] ERR_TEXT_LONG    = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last_item;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] match_position;
        logic        match_found;
        logic [1:0]  error_code;
    } t_out_beat;

    typedef struct packed {
        logic pat_shift;
        logic txt_shift;
    } t_cell_ctl;

endpackage

@@ rtl/sfp_cell.sv @@
// One cell of the search chain: one pattern byte, one window byte and an active flag.
// Depends on sfp_pkg for the cell control struct.
// Hands its pattern, flag and window byte to the next cell each shift.
module sfp_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfp_pkg::t_cell_ctl   i_ctl,
    input  logic [7:0]           i_pat,
    input  logic                 i_act,
    input  logic [7:0]           i_txt,
    output logic [7:0]           o_pat,
    output logic                 o_act,
    output logic [7:0]           o_txt,
    output logic                 o_eq
);

    logic [7:0] r_pat;
    logic [7:0] r_txt;
    logic       r_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_ctl.pat_shift) begin
            r_act <= i_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_shift) begin
            r_pat <= i_pat;
        end
        if (i_ctl.txt_shift) begin
            r_txt <= i_txt;
        end
    end

    // Compares the byte this cell is about to take against its pattern byte.
    assign o_eq  = ~r_act | (i_txt == r_pat);
    assign o_pat = r_pat;
    assign o_act = r_act;
    assign o_txt = r_txt;

endmodule

@@ rtl/substring_first_position_top.sv @@
// Top level of the substring first-position search block.
// Depends on sfp_pkg and instantiates a row of sfp_cell.
//
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_data  (sfp_pkg::t_in_beat)
// out       output     o_out_valid / i_out_ready  o_out_data (sfp_pkg::t_out_beat)
//
// The whole pattern is compared across all cells in the cycle a text beat is taken.
// The result of a final text beat is registered and shown from the next cycle on.
// Input beats are taken while the result register is empty or being drained.
// Reset clears lengths, counters, other flags and the result valid, and sets r_closed; no clearing pass is needed.
module substring_first_position_top #(
    parameter int               MAX_PATTERN = sfp_pkg::MAX_PATTERN,
    parameter longint unsigned  MAX_TEXT    = sfp_pkg::MAX_TEXT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sfp_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sfp_pkg::t_out_beat  o_out_data
);

    localparam int PL_W  = $clog2(MAX_PATTERN + 1);
    localparam int TXT_W = $clog2(MAX_TEXT + 64'd1);
    localparam int CMP_W = (TXT_W > PL_W) ? TXT_W : PL_W;

    logic [PL_W-1:0]   r_len;
    logic              r_closed;
    logic              r_pat_ovf;
    logic [TXT_W-1:0]  r_count;
    logic              r_txt_ovf;
    logic [TXT_W-1:0]  r_first;
    logic              r_out_vld;
    sfp_pkg::t_out_beat r_out;

    logic              w_accept;
    logic              w_is_pat;
    logic              w_is_txt;
    logic              w_pat_room;
    logic              w_txt_room;
    logic [TXT_W-1:0]  n_count;
    logic [CMP_W-1:0]  w_cnt_ext;
    logic [CMP_W-1:0]  w_len_ext;
    logic              w_hit;
    logic [TXT_W-1:0]  n_first;
    sfp_pkg::t_cell_ctl w_ctl;

    logic [7:0]             w_pat [0:MAX_PATTERN-1];
    logic [7:0]             w_txt [0:MAX_PATTERN-1];
    logic [MAX_PATTERN-1:0] w_act;
    logic [MAX_PATTERN-1:0] w_eq;

    assign o_in_ready = ~r_out_vld | i_out_ready;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_is_pat   = w_accept & (i_in_data.req_type == sfp_pkg::REQ_PATTERN);
    assign w_is_txt   = w_accept & (i_in_data.req_type == sfp_pkg::REQ_TEXT);

    assign w_pat_room = r_closed | (r_len < PL_W'(MAX_PATTERN));
    assign w_txt_room = r_count < TXT_W'(MAX_TEXT);

    assign w_ctl.pat_shift = w_is_pat & w_pat_room;
    assign w_ctl.txt_shift = w_is_txt & w_txt_room;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [7:0] w_pat_in;
        logic [7:0] w_txt_in;
        logic       w_act_in;
        if (k == 0) begin : g_head
            assign w_pat_in = i_in_data.data_byte;
            assign w_txt_in = i_in_data.data_byte;
            assign w_act_in = 1'b1;
        end else begin : g_body
            assign w_pat_in = w_pat[k-1];
            assign w_txt_in = w_txt[k-1];
            assign w_act_in = w_act[k-1] & ~r_closed;
        end
        sfp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_pat   (w_pat_in),
            .i_act   (w_act_in),
            .i_txt   (w_txt_in),
            .o_pat   (w_pat[k]),
            .o_act   (w_act[k]),
            .o_txt   (w_txt[k]),
            .o_eq    (w_eq[k])
        );
    end

    assign n_count   = r_count + TXT_W'(1);
    assign w_cnt_ext = CMP_W'(n_count);
    assign w_len_ext = CMP_W'(r_len);
    assign w_hit     = (r_first == '0) && (r_len != '0) && (w_cnt_ext >= w_len_ext) && (&w_eq);
    assign n_first   = TXT_W'(w_cnt_ext - w_len_ext + CMP_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_closed  <= 1'b1;
            r_pat_ovf <= 1'b0;
            r_count   <= '0;
            r_txt_ovf <= 1'b0;
            r_first   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_is_txt && i_in_data.last_item) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_is_pat) begin
                if (r_closed) begin
                    r_len     <= PL_W'(1);
                    r_pat_ovf <= 1'b0;
                    r_count   <= '0;
                    r_txt_ovf <= 1'b0;
                    r_first   <= '0;
                end else if (w_pat_room) begin
                    r_len <= r_len + PL_W'(1);
                end else begin
                    r_pat_ovf <= 1'b1;
                end
                r_closed <= i_in_data.last_item;
            end else if (w_is_txt) begin
                r_closed <= 1'b1;
                if (i_in_data.last_item) begin
                    r_count   <= '0;
                    r_txt_ovf <= 1'b0;
                    r_first   <= '0;
                end else if (w_txt_room) begin
                    r_count <= n_count;
                    if (w_hit) begin
                        r_first <= n_first;
                    end
                end else begin
                    r_txt_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_is_txt && i_in_data.last_item) begin
            if (w_txt_room && w_hit) begin
                r_out.match_position <= 16'(n_first);
                r_out.match_found    <= 1'b1;
            end else begin
                r_out.match_position <= 16'(r_first);
                r_out.match_found    <= (r_first != '0);
            end
            if (r_pat_ovf) begin
                r_out.error_code <= sfp_pkg::ERR_PATTERN_LONG;
            end else if (r_txt_ovf || !w_txt_room) begin
                r_out.error_code <= sfp_pkg::ERR_TEXT_LONG;
            end else begin
                r_out.error_code <= sfp_pkg::ERR_NONE;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
